[sv/sftp_pkg.sv]
// shared types and constants for the swing foot trajectory point block
`timescale 1ns / 1ps
`default_nettype none

package sftp_pkg;

   // fixed-point widths
   localparam int POS_W       = 16;
   localparam int PHASE_W     = 16;
   localparam int CLEARANCE_W = 13;

   // reset value of the clearance register, 0.1 m in unsigned Q0.13
   localparam logic [CLEARANCE_W-1:0] CLEARANCE_RESET = 13'd819;

   // phase 0.5 and 1.0 in Q1.15
   localparam logic [PHASE_W-1:0] PHASE_HALF = 16'd16384;
   localparam logic [PHASE_W-1:0] PHASE_ONE  = 16'd32768;

   // z parabola coefficient and x/y span widths
   localparam int COEF_W = 20;
   localparam int DIFF_W = 17;

   // input word
   typedef struct packed {
      logic        [PHASE_W-1:0] swing_phase;
      logic signed [POS_W-1:0]   start_x;
      logic signed [POS_W-1:0]   start_y;
      logic signed [POS_W-1:0]   start_z;
      logic signed [POS_W-1:0]   end_x;
      logic signed [POS_W-1:0]   end_y;
      logic signed [POS_W-1:0]   end_z;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [POS_W-1:0] foot_x;
      logic signed [POS_W-1:0] foot_y;
      logic signed [POS_W-1:0] foot_z;
   } rsp_type;

   // geometry terms that travel beside the phase path
   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [DIFF_W-1:0] diff_x;
      logic signed [DIFF_W-1:0] diff_y;
      logic signed [POS_W-1:0]  start_x;
      logic signed [POS_W-1:0]  start_y;
      logic signed [POS_W-1:0]  start_z;
   } geom_type;

endpackage

`default_nettype wire

[sv/sftp_sine_rom.sv]
// quarter-wave sine table with two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module sftp_sine_rom
   import sftp_pkg::*;
#(
   parameter int SINE_TABLE_ENTRIES = 256,
   parameter int IDX_W              = 9
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [IDX_W-1:0] rd_idx_lo,
   input  wire logic [IDX_W-1:0] rd_idx_hi,
   output      logic [15:0]      rd_data_lo,
   output      logic [15:0]      rd_data_hi
);

   localparam int          Depth      = SINE_TABLE_ENTRIES + 1;
   localparam logic [63:0] TableDepth = 64'(SINE_TABLE_ENTRIES);
   localparam logic [63:0] HalfPiQ30  = 64'd1686629713;
   localparam logic [63:0] TaylorDiv [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

   typedef logic [15:0] rom_type [Depth];

   // taylor series of sin(k*pi/2/N) in Q2.30, rounded to Q1.15
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] theta;
      logic [63:0] term;
      logic [63:0] sum;
      for (int k = 0; k < Depth; k++) begin
         theta = (HalfPiQ30 * 64'(k)) / TableDepth;
         term  = theta;
         sum   = theta;
         for (int n = 1; n <= 8; n++) begin
            term = (term * theta) >> 30;
            term = (term * theta) >> 30;
            term = term / TaylorDiv[n-1];
            if (n % 2 == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         sum = (sum + 64'd16384) >> 15;
         if (sum > 64'd32768) begin
            sum = 64'd32768;
         end
         rom[k] = 16'(sum);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [15:0] rd_data_lo_ff;
   logic [15:0] rd_data_hi_ff;

   // registered reads of both neighbors
   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_lo_ff <= SINE_ROM[rd_idx_lo];
         rd_data_hi_ff <= SINE_ROM[rd_idx_hi];
      end
   end

   assign rd_data_lo = rd_data_lo_ff;
   assign rd_data_hi = rd_data_hi_ff;

endmodule

`default_nettype wire

[sv/sftp_warp.sv]
// phase warp pipeline: clamp, sine lookup, interpolation, scale by 0.8 in the first half, linear ramp in the second
`timescale 1ns / 1ps
`default_nettype none

module sftp_warp
   import sftp_pkg::*;
#(
   parameter int SINE_TABLE_ENTRIES = 256
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [PHASE_W-1:0] swing_phase,
   output      logic [15:0]        warped
);

   localparam int          IdxW  = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int          PosW  = 14 + IdxW;
   localparam logic [20:0] Recip5 = 21'd419431;

   // stage 1: clamp phase, split table position
   logic [15:0]     phase_c;
   logic            low_half;
   logic [14:0]     phase_lo;
   logic [PosW-1:0] pos;
   logic [17:0]     num_hi;

   logic            low1_ff;
   logic [IdxW-1:0] idx1_ff;
   logic [13:0]     frac1_ff;
   logic [17:0]     num_hi1_ff;

   always_comb begin
      phase_c  = (swing_phase > PHASE_ONE) ? PHASE_ONE : swing_phase;
      low_half = (phase_c <= PHASE_HALF);
      phase_lo = low_half ? phase_c[14:0] : 15'd0;
      pos      = PosW'(phase_lo) * PosW'(SINE_TABLE_ENTRIES);
      num_hi   = 18'd131074 + {1'b0, phase_c, 1'b0} - 18'd32768;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         low1_ff    <= low_half;
         idx1_ff    <= pos[PosW-1:14];
         frac1_ff   <= pos[13:0];
         num_hi1_ff <= num_hi;
      end
   end

   // stage 2: table read of both neighbors
   logic [IdxW-1:0] idx_next;
   logic [15:0]     sine_lo;
   logic [15:0]     sine_hi;

   logic            low2_ff;
   logic [13:0]     frac2_ff;
   logic [17:0]     num_hi2_ff;

   assign idx_next = (idx1_ff == IdxW'(SINE_TABLE_ENTRIES)) ? idx1_ff : idx1_ff + 1'b1;

   sftp_sine_rom #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
      .IDX_W             (IdxW)
   ) u_rom (
      .clock     (clock),
      .en        (en),
      .rd_idx_lo (idx1_ff),
      .rd_idx_hi (idx_next),
      .rd_data_lo(sine_lo),
      .rd_data_hi(sine_hi)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         low2_ff    <= low1_ff;
         frac2_ff   <= frac1_ff;
         num_hi2_ff <= num_hi1_ff;
      end
   end

   // stage 3: linear interpolation, round, form numerator of the 0.8 scale
   logic [30:0] interp;
   logic [15:0] sine_r;
   logic [17:0] num3_ff;

   always_comb begin
      interp = 31'(sine_lo) * 31'(15'd16384 - {1'b0, frac2_ff})
             + 31'(sine_hi) * 31'(frac2_ff);
      sine_r = 16'((interp + 31'd8192) >> 14);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num3_ff <= low2_ff ? ({sine_r, 2'b00} + 18'd2) : num_hi2_ff;
      end
   end

   // stage 4: divide by five through reciprocal multiply
   logic [38:0] quot;
   logic [15:0] warped4_ff;

   assign quot = 39'(num3_ff) * 39'(Recip5);

   always_ff @(posedge clock) begin
      if (en) begin
         warped4_ff <= quot[36:21];
      end
   end

   assign warped = warped4_ff;

endmodule

`default_nettype wire

[sv/sftp_blend.sv]
// position pipeline: x/y interpolation and z parabola, saturated output word
`timescale 1ns / 1ps
`default_nettype none

module sftp_blend
   import sftp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     en,
   input  wire logic [15:0] warped,
   input  wire geom_type geom,
   output      rsp_type  rsp_data
);

   // clamp to the 16-bit signed range
   function automatic logic signed [POS_W-1:0] sat16(input logic signed [25:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 26'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -26'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   // stage 5: products with the warped phase
   logic signed [16:0] w_s;
   logic signed [33:0] prod_x;
   logic signed [33:0] prod_y;
   logic signed [36:0] poly;

   logic signed [33:0]      prod_x5_ff;
   logic signed [33:0]      prod_y5_ff;
   logic signed [36:0]      poly5_ff;
   logic signed [16:0]      w5_ff;
   logic signed [POS_W-1:0] sx5_ff;
   logic signed [POS_W-1:0] sy5_ff;
   logic signed [POS_W-1:0] sz5_ff;

   always_comb begin
      w_s    = signed'({1'b0, warped});
      prod_x = 34'(w_s) * 34'(geom.diff_x);
      prod_y = 34'(w_s) * 34'(geom.diff_y);
      poly   = 37'(geom.coef_a) * 37'(w_s) + (37'(geom.coef_b) <<< 15);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x5_ff <= prod_x;
         prod_y5_ff <= prod_y;
         poly5_ff   <= poly;
         w5_ff      <= w_s;
         sx5_ff     <= geom.start_x;
         sy5_ff     <= geom.start_y;
         sz5_ff     <= geom.start_z;
      end
   end

   // stage 6: x/y round and saturate, z product
   logic signed [33:0] rnd_x;
   logic signed [33:0] rnd_y;
   logic signed [53:0] zprod;

   logic signed [POS_W-1:0] x6_ff;
   logic signed [POS_W-1:0] y6_ff;
   logic signed [53:0]      zprod6_ff;
   logic signed [POS_W-1:0] sz6_ff;

   always_comb begin
      rnd_x = (prod_x5_ff + 34'sd16384) >>> 15;
      rnd_y = (prod_y5_ff + 34'sd16384) >>> 15;
      zprod = 54'(poly5_ff) * 54'(w5_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x6_ff     <= sat16(26'(sx5_ff) + 26'(rnd_x));
         y6_ff     <= sat16(26'(sy5_ff) + 26'(rnd_y));
         zprod6_ff <= zprod;
         sz6_ff    <= sz5_ff;
      end
   end

   // stage 7: z round, offset, saturate into the output register
   logic signed [53:0] rnd_z;
   rsp_type            rsp_data_ff;

   assign rnd_z = (zprod6_ff + 54'sd536870912) >>> 30;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.foot_x <= x6_ff;
         rsp_data_ff.foot_y <= y6_ff;
         rsp_data_ff.foot_z <= sat16(26'(sz6_ff) + 26'(rnd_z));
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

[sv/swing_foot_trajectory_point.sv]
// Swing foot trajectory point generator, top level.
// Each req_ word carries a swing phase (Q1.15) and the start and end foot
// positions (signed Q2.13). The block returns one rsp_ word per req_ word with
// the desired foot x, y and z at that phase, saturated to 16 bits.
// A word is taken at a clock edge where req_valid is high and req_stall low;
// a result is handed over where rsp_valid is high and rsp_stall low.
// The datapath is a seven-stage pipeline (clamp and table address, sine read,
// interpolation, divide by five, products, x/y rounding with z product, z
// rounding into the output register); one word per cycle is sustained while
// rsp_stall stays low.
// While a result waits with rsp_stall high the whole pipeline holds and
// req_stall goes high; nothing is dropped or repeated.
// The csr_ port writes the 13-bit clearance and is always ready; write it only
// while the pipeline is empty. Synchronous reset empties the pipeline and sets
// clearance to 0.1 m; the sine table is constant and needs no preload.
`timescale 1ns / 1ps
`default_nettype none

module swing_foot_trajectory_point
   import sftp_pkg::*;
#(
   parameter int SINE_TABLE_ENTRIES = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire req_type                req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rsp_type                rsp_data,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CLEARANCE_W-1:0] csr_data
);

   localparam int Stages = 6;

   logic en;
   logic rsp_valid_ff;

   // clearance register
   logic [CLEARANCE_W-1:0] clearance_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearance_ff <= CLEARANCE_RESET;
      end else if (csr_valid && csr_ready) begin
         clearance_ff <= csr_data;
      end
   end

   // pipeline advances unless a finished word is held at the output
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // valid bits travel with the words
   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;

   assign vld_in = {vld_ff[Stages-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[Stages-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // stage 1: parabola coefficients and x/y spans
   logic signed [16:0] mid;
   logic signed [17:0] d1;
   logic signed [17:0] d2;
   geom_type           geom1;

   always_comb begin
      mid = ((req_data.start_z > req_data.end_z) ? 17'(req_data.start_z)
                                                 : 17'(req_data.end_z))
          + signed'({4'b0000, clearance_ff});
      d1  = 18'(mid) - 18'(req_data.start_z);
      d2  = 18'(req_data.end_z) - 18'(req_data.start_z);
      geom1.coef_a  = (COEF_W'(d2) <<< 1) - (COEF_W'(d1) <<< 2);
      geom1.coef_b  = (COEF_W'(d1) <<< 2) - COEF_W'(d2);
      geom1.diff_x  = DIFF_W'(req_data.end_x) - DIFF_W'(req_data.start_x);
      geom1.diff_y  = DIFF_W'(req_data.end_y) - DIFF_W'(req_data.start_y);
      geom1.start_x = req_data.start_x;
      geom1.start_y = req_data.start_y;
      geom1.start_z = req_data.start_z;
   end

   // geometry delay line matching the four warp stages
   geom_type geom_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         geom_ff[0] <= geom1;
         geom_ff[1] <= geom_ff[0];
         geom_ff[2] <= geom_ff[1];
         geom_ff[3] <= geom_ff[2];
      end
   end

   // phase warp, stages 1 to 4
   logic [15:0] warped;

   sftp_warp #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
   ) u_warp (
      .clock      (clock),
      .en         (en),
      .swing_phase(req_data.swing_phase),
      .warped     (warped)
   );

   // position blend, stages 5 to 7
   sftp_blend u_blend (
      .clock   (clock),
      .en      (en),
      .warped  (warped),
      .geom    (geom_ff[3]),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for the swing foot trajectory point block
`timescale 1ns / 1ps

module testbench
   import sftp_pkg::*;
();

   localparam int    TABLE_N    = 256;
   localparam real   CLK_PERIOD = 12.0;
   localparam int    LONG_HOLD  = 80;
   localparam int    MAX_CYCLES = 200000;
   localparam int    MAX_REPORT = 10;

   // block ports
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CLEARANCE_W-1:0] csr_data  = '0;

   // words waiting to be sent and foot points waiting to come back
   req_type pending_points [$];
   rsp_type foot_expected  [$];

   // predictor state
   longint sine_q15 [0:TABLE_N];
   longint clearance_q = longint'(CLEARANCE_RESET);

   // idling controls set from the stimulus sequence
   logic req_gaps_on   = 1'b1;
   logic rsp_gaps_on   = 1'b1;
   int   hold_requests = 0;

   int failures    = 0;
   int cycle_count = 0;

   swing_foot_trajectory_point DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2.0) clock = ~clock;

   // quarter-wave sine entry in Q1.15 from a Q2.30 Taylor series
   function automatic longint sine_rom_value(input int k);
      longint unsigned theta, term, sum;
      theta = (64'd1686629713 * longint'(k)) / longint'(TABLE_N);
      term  = theta;
      sum   = theta;
      for (int n = 1; n <= 8; n++) begin
         term = (term * theta) >> 30;
         term = (term * theta) >> 30;
         term = term / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      sum = (sum + 64'd16384) >> 15;
      if (sum > 64'd32768) begin
         sum = 64'd32768;
      end
      return longint'(sum);
   endfunction

   // warped phase: scaled sine in the first half, linear ramp in the second
   function automatic longint warp_q15(input longint phase);
      longint pos, idx, frac, s;
      if (phase > longint'(PHASE_ONE)) begin
         phase = longint'(PHASE_ONE);
      end
      if (phase <= longint'(PHASE_HALF)) begin
         pos  = phase * TABLE_N;
         idx  = pos >>> 14;
         frac = pos & 64'h3FFF;
         if (idx >= TABLE_N) begin
            s = sine_q15[TABLE_N];
         end else begin
            s = (sine_q15[idx] * (16384 - frac) + sine_q15[idx + 1] * frac + 8192) >>> 14;
         end
         return (4 * s + 2) / 5;
      end
      return (131072 + 2 * (phase - longint'(PHASE_HALF)) + 2) / 5;
   endfunction

   function automatic logic signed [POS_W-1:0] clip16(input longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return v[POS_W-1:0];
   endfunction

   // foot position for one word at the given clearance
   function automatic rsp_type predict_foot(input req_type r, input longint clr);
      longint  w, sx, sy, sz, ex, ey, ez, mid, d1, d2, ca, cb, z;
      rsp_type f;
      w   = warp_q15(longint'(r.swing_phase));
      sx  = longint'($signed(r.start_x));
      sy  = longint'($signed(r.start_y));
      sz  = longint'($signed(r.start_z));
      ex  = longint'($signed(r.end_x));
      ey  = longint'($signed(r.end_y));
      ez  = longint'($signed(r.end_z));
      mid = ((sz > ez) ? sz : ez) + clr;
      d1  = mid - sz;
      d2  = ez - sz;
      ca  = 2 * d2 - 4 * d1;
      cb  = 4 * d1 - d2;
      z   = sz + ((ca * w * w + cb * w * 32768 + (64'sd1 <<< 29)) >>> 30);
      f.foot_x = clip16(sx + ((w * (ex - sx) + 16384) >>> 15));
      f.foot_y = clip16(sy + ((w * (ey - sy) + 16384) >>> 15));
      f.foot_z = clip16(z);
      return f;
   endfunction

   // sender: one word per handshake, random gap drawn after each
   always @(posedge clock) begin
      int gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            foot_expected.push_back(predict_foot(req_data, clearance_q));
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_points.size() != 0) begin
            req_data  <= pending_points.pop_front();
            req_valid <= 1'b1;
            gap_left = req_gaps_on ? $urandom_range(0, 8) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: check each word, then stall a random count or a long hold
   always @(posedge clock) begin
      int      stall_left;
      int      long_left;
      int      hold_served;
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left  = 0;
         long_left   = 0;
         hold_served = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (foot_expected.size() == 0) begin
               if (failures < MAX_REPORT) begin
                  $display("unexpected word: x=%0d y=%0d z=%0d",
                           rsp_data.foot_x, rsp_data.foot_y, rsp_data.foot_z);
               end
               failures++;
            end else begin
               want = foot_expected.pop_front();
               if (rsp_data.foot_x !== want.foot_x || rsp_data.foot_y !== want.foot_y
                   || rsp_data.foot_z !== want.foot_z) begin
                  if (failures < MAX_REPORT) begin
                     $display("mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                              want.foot_x, want.foot_y, want.foot_z,
                              rsp_data.foot_x, rsp_data.foot_y, rsp_data.foot_z);
                  end
                  failures++;
               end
            end
            stall_left = rsp_gaps_on ? $urandom_range(0, 8) : 0;
         end
         if (long_left == 0 && hold_served != hold_requests) begin
            hold_served = hold_requests;
            long_left   = LONG_HOLD;
         end
         if (long_left > 0) begin
            long_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push_point(input logic [PHASE_W-1:0] p,
                             input logic signed [POS_W-1:0] sx, sy, sz, ex, ey, ez);
      req_type r;
      r.swing_phase = p;
      r.start_x = sx;
      r.start_y = sy;
      r.start_z = sz;
      r.end_x   = ex;
      r.end_y   = ey;
      r.end_z   = ez;
      pending_points.push_back(r);
   endtask

   function automatic logic signed [POS_W-1:0] rand_pos();
      case ($urandom_range(0, 4))
         0, 1: return POS_W'($urandom);
         2: return POS_W'($urandom_range(0, 6000) - 3000);
         3: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return POS_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // mostly in-range phases, with the half point, the end and overrange mixed in
   task automatic push_random(input int count);
      logic [PHASE_W-1:0] p;
      repeat (count) begin
         case ($urandom_range(0, 19))
            0: p = PHASE_HALF;
            1: p = PHASE_ONE;
            2: p = PHASE_W'($urandom_range(32769, 65535));
            3, 4, 5: p = PHASE_W'($urandom_range(0, 16384));
            default: p = PHASE_W'($urandom_range(0, 32768));
         endcase
         push_point(p, rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos());
      end
   endtask

   // wait until every word is sent and every foot point is back
   task automatic wait_drained();
      @(posedge clock);
      while (pending_points.size() != 0 || req_valid || foot_expected.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_clearance(input logic [CLEARANCE_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      clearance_q = longint'(v);
   endtask

   // stimulus sequence
   initial begin
      for (int k = 0; k <= TABLE_N; k++) begin
         sine_q15[k] = sine_rom_value(k);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed points at the reset clearance
      push_point(16'd0,     16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      push_point(16'd0,     -16'sd1000, 16'sd2000, 16'sd0, 16'sd3000, -16'sd500, 16'sd0);
      push_point(16'd1,     -16'sd1000, 16'sd2000, 16'sd100, 16'sd3000, -16'sd500, 16'sd0);
      push_point(16'd8192,  16'sd0, 16'sd0, 16'sd0, 16'sd8192, -16'sd8192, 16'sd0);
      push_point(16'd16383, 16'sd0, 16'sd0, 16'sd0, 16'sd8192, -16'sd8192, 16'sd0);
      push_point(16'd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd8192, -16'sd8192, 16'sd0);
      push_point(16'd16385, 16'sd0, 16'sd0, 16'sd0, 16'sd8192, -16'sd8192, 16'sd0);
      push_point(16'd24576, 16'sd500, -16'sd500, -16'sd2000, 16'sd4000, 16'sd0, 16'sd1000);
      push_point(16'd32767, 16'sd500, -16'sd500, -16'sd2000, 16'sd4000, 16'sd0, 16'sd1000);
      push_point(16'd32768, 16'sd500, -16'sd500, -16'sd2000, 16'sd4000, 16'sd0, 16'sd1000);
      // phase above one clamps to the end point
      push_point(16'd32769, 16'sd500, -16'sd500, -16'sd2000, 16'sd4000, 16'sd0, 16'sd1000);
      push_point(16'hFFFF,  16'sd500, -16'sd500, -16'sd2000, 16'sd4000, 16'sd0, 16'sd1000);
      // position extremes in both directions
      push_point(16'd16384, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      push_point(16'd16384, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
      push_point(16'd32768, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      push_point(16'd4096,  16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      // mid point above the 16-bit range
      push_point(16'd16384, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sh7FFF);
      push_point(16'd8192,  16'sd0, 16'sd0, 16'sd32000, 16'sd0, 16'sd0, 16'sh7FFF);
      // alternating bit patterns
      push_point(16'h5555,  16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
      push_point(16'hAAAA,  16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
      wait_drained();

      // zero clearance, no idling on either side
      write_clearance(13'd0);
      req_gaps_on <= 1'b0;
      rsp_gaps_on <= 1'b0;
      push_random(120);
      wait_drained();

      // full clearance, long receiver hold while the sender keeps offering
      write_clearance(13'h1FFF);
      hold_requests <= hold_requests + 1;
      push_random(60);
      wait_drained();
      req_gaps_on <= 1'b1;
      rsp_gaps_on <= 1'b1;
      push_random(100);
      wait_drained();

      // random clearance, idling on both sides
      write_clearance(CLEARANCE_W'($urandom_range(0, 8191)));
      push_random(150);
      wait_drained();

      // sender idles, receiver always takes
      write_clearance(13'd4096);
      rsp_gaps_on <= 1'b0;
      push_random(100);
      wait_drained();

      // back to the reset value, receiver idles, sender streams
      write_clearance(CLEARANCE_RESET);
      req_gaps_on <= 1'b0;
      rsp_gaps_on <= 1'b1;
      push_random(110);
      wait_drained();

      repeat (20) @(posedge clock);
      if (failures == 0 && foot_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
